// File: rtl/kmw_pkg.sv
// ----------------------------------------------------------------------------
// kmw_pkg: shared types and constants for the weighted Kaplan-Meier block
// Field widths, the queue item layout, the back-end state encoding and the
// saturating accumulator add used by the tables and the total.
// ----------------------------------------------------------------------------
package kmw_pkg;

    localparam int BIN_W  = 6;   // time bin fields
    localparam int W_W    = 24;  // subject weight, unsigned Q8.16
    localparam int ACC_W  = 40;  // accumulators, unsigned Q24.16
    localparam int SURV_W = 17;  // survival, unsigned Q1.16
    localparam int AR_W   = ACC_W + 8; // signed at-risk weight, room for 64 subtractions

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [ACC_W-1:0]  ACC_MAX = {ACC_W{1'b1}};
    localparam logic [SURV_W-1:0] ONE_Q16 = 17'h10000;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             ev;
        logic [W_W-1:0]   w;
        logic             last;
        logic             keep;   // bin lies within the active range
    } kmw_item_t;

    typedef struct packed {
        logic              start;
        logic [SURV_W-1:0] surv;
        logic [ACC_W-1:0]  n;
        logic [ACC_W-1:0]  d;
    } kmw_div_req_t;

    typedef struct packed {
        logic              done;
        logic [SURV_W-1:0] quot;
    } kmw_div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_W0_RD,
        ST_W0_CALC,
        ST_RD,
        ST_CALC,
        ST_DIV,
        ST_EMIT
    } kmw_state_t;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [W_W-1:0]   b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {{(ACC_W + 1 - W_W){1'b0}}, b};
        return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
    endfunction

endpackage

// File: rtl/kmw_ram.sv
// ----------------------------------------------------------------------------
// kmw_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module kmw_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/kmw_front.sv
// ----------------------------------------------------------------------------
// kmw_front: subject intake
// Accepts subjects, marks whether each one's bin lies within the active range, and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module kmw_front
    import kmw_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [BIN_W-1:0] s_time_bin,
    input  logic             s_is_event,
    input  logic [W_W-1:0]   s_weight,
    input  logic             s_batch_last,
    input  logic [BIN_W-1:0] nt_eff,
    output logic             q_valid,
    output kmw_item_t        q_item,
    input  logic             q_pop
);

    kmw_item_t           q_mem_reg [QDEPTH];
    kmw_item_t           item_in;
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                push, pop;

    always_comb begin
        item_in.bin  = s_time_bin;
        item_in.ev   = s_is_event;
        item_in.w    = s_weight;
        item_in.last = s_batch_last;
        item_in.keep = (s_time_bin <= nt_eff);
    end

    assign s_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = q_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// File: rtl/kmw_div.sv
// ----------------------------------------------------------------------------
// kmw_div: survival update unit
// Computes floor(surv * n / d) for n <= d, one survival bit per cycle, by
// folding the multiply into a radix-2 long division with digits 0 to 2.
// ----------------------------------------------------------------------------
module kmw_div
    import kmw_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  kmw_div_req_t req,
    output kmw_div_rsp_t rsp
);

    localparam int STEP_W = $clog2(SURV_W);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SURV_W-1:0]   surv_reg;
    logic [SURV_W-1:0]   q_reg, q_step;
    logic [ACC_W-1:0]    n_reg, d_reg, r_reg, r_next;
    logic [ACC_W+1:0]    t, d1, d2, r_step;
    logic [1:0]          dig;

    // Remainder stays below d, so 2r + n stays below 3d.
    always_comb begin
        t  = {1'b0, r_reg, 1'b0} + {2'b00, (surv_reg[SURV_W-1] ? n_reg : '0)};
        d1 = {2'b00, d_reg};
        d2 = {1'b0, d_reg, 1'b0};
        priority if (t >= d2) begin
            r_step = t - d2;
            dig    = 2'd2;
        end else if (t >= d1) begin
            r_step = t - d1;
            dig    = 2'd1;
        end else begin
            r_step = t;
            dig    = 2'd0;
        end
        r_next = r_step[ACC_W-1:0];
        q_step = {q_reg[SURV_W-2:0], 1'b0} + {{(SURV_W - 2){1'b0}}, dig};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SURV_W - 1);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            surv_reg <= req.surv;
            n_reg    <= req.n;
            d_reg    <= req.d;
            r_reg    <= '0;
            q_reg    <= '0;
        end else if (busy_reg) begin
            surv_reg <= {surv_reg[SURV_W-2:0], 1'b0};
            r_reg    <= r_next;
            q_reg    <= q_step;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

// File: rtl/kmw_back.sv
// ----------------------------------------------------------------------------
// kmw_back: accumulation and curve walk
// Drains the subject queue into the removal and event tables, then on the
// last subject of a batch walks the bins and issues the survival curve.
// ----------------------------------------------------------------------------
module kmw_back
    import kmw_pkg::*;
#(
    parameter int TIME_BINS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  kmw_item_t         q_item,
    output logic              q_pop,
    input  logic [BIN_W-1:0]  nt_eff,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BIN_W-1:0]  m_bin_index,
    output logic [SURV_W-1:0] m_survival,
    output logic              m_curve_last
);

    localparam int ADDR_W = $clog2(TIME_BINS);

    kmw_state_t            state_reg, state_next;
    kmw_item_t             item_reg, item_next;
    logic [ACC_W-1:0]      total_reg, total_next;
    logic [TIME_BINS-1:0]  tab_vld_reg, tab_vld_next;
    logic                  rd_vld_reg;
    logic [BIN_W-1:0]      j_reg, j_next;
    logic [BIN_W-1:0]      nt_walk_reg, nt_walk_next;
    logic signed [AR_W-1:0] at_risk_reg, at_risk_next;
    logic signed [AR_W-1:0] ew_ext, ar_diff;
    logic [ACC_W-1:0]      rw_reg, rw_next;
    logic [SURV_W-1:0]     surv_reg, surv_next;

    logic [ADDR_W-1:0]     raddr, waddr;
    logic                  ram_we;
    logic [ACC_W-1:0]      rem_rdata, evt_rdata, rem_rd, evt_rd;
    logic [ACC_W-1:0]      rem_wdata, evt_wdata;

    kmw_div_req_t          div_req;
    kmw_div_rsp_t          div_rsp;
    logic                  div_go;

    logic                  out_free, out_load;
    logic                  m_valid_reg;
    logic [BIN_W-1:0]      m_bin_index_reg;
    logic [SURV_W-1:0]     m_survival_reg;
    logic                  m_curve_last_reg;

    kmw_ram #(.WIDTH(ACC_W), .DEPTH(TIME_BINS)) u_rem_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (rem_wdata),
        .raddr (raddr),
        .rdata (rem_rdata)
    );

    kmw_ram #(.WIDTH(ACC_W), .DEPTH(TIME_BINS)) u_evt_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (evt_wdata),
        .raddr (raddr),
        .rdata (evt_rdata)
    );

    kmw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Entries not written since the last clear read as zero.
    assign rem_rd = rd_vld_reg ? rem_rdata : '0;
    assign evt_rd = rd_vld_reg ? evt_rdata : '0;

    assign waddr     = item_reg.bin[ADDR_W-1:0];
    assign rem_wdata = sat_add(rem_rd, item_reg.w);
    assign evt_wdata = item_reg.ev ? sat_add(evt_rd, item_reg.w) : evt_rd;

    always_comb begin
        priority if (state_reg == ST_IDLE) begin
            raddr = q_item.bin[ADDR_W-1:0];
        end else if (state_reg == ST_W0_RD) begin
            raddr = '0;
        end else begin
            raddr = j_reg[ADDR_W-1:0];
        end
    end

    assign ew_ext  = $signed({{(AR_W - ACC_W){1'b0}}, evt_rd});
    assign ar_diff = at_risk_reg - ew_ext;
    assign div_go  = (at_risk_reg > 0) && (ew_ext < at_risk_reg);
    assign out_free = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    priority if (q_item.keep) begin
                        state_next = ST_ACC;
                    end else if (q_item.last) begin
                        state_next = ST_W0_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ACC:     state_next = item_reg.last ? ST_W0_RD : ST_IDLE;
            ST_W0_RD:   state_next = ST_W0_CALC;
            ST_W0_CALC: state_next = ST_EMIT;
            ST_RD:      state_next = ST_CALC;
            ST_CALC:    state_next = div_go ? ST_DIV : ST_EMIT;
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = (j_reg == nt_walk_reg) ? ST_IDLE : ST_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Controls and datapath next values.
    always_comb begin
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        out_load     = 1'b0;
        item_next    = item_reg;
        total_next   = total_reg;
        tab_vld_next = tab_vld_reg;
        j_next       = j_reg;
        nt_walk_next = nt_walk_reg;
        at_risk_next = at_risk_reg;
        rw_next      = rw_reg;
        surv_next    = surv_reg;
        div_req      = '0;
        div_req.surv = surv_reg;
        div_req.n    = ar_diff[ACC_W-1:0];
        div_req.d    = at_risk_reg[ACC_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                q_pop     = q_valid;
                item_next = q_item;
            end
            ST_ACC: begin
                ram_we     = 1'b1;
                total_next = sat_add(total_reg, item_reg.w);
                tab_vld_next[item_reg.bin[ADDR_W-1:0]] = 1'b1;
            end
            ST_W0_RD: begin
                nt_walk_next = nt_eff;
                j_next       = '0;
                rw_next      = '0;
            end
            ST_W0_CALC: begin
                at_risk_next = $signed({{(AR_W - ACC_W){1'b0}}, total_reg})
                             - $signed({{(AR_W - ACC_W){1'b0}}, rem_rd});
                surv_next    = ONE_Q16;
            end
            ST_RD: begin
            end
            ST_CALC: begin
                rw_next       = rem_rd;
                div_req.start = div_go;
                if (!div_go) begin
                    surv_next = '0;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    surv_next = div_rsp.quot;
                end
            end
            ST_EMIT: begin
                out_load = out_free;
                if (out_free) begin
                    at_risk_next = at_risk_reg - $signed({{(AR_W - ACC_W){1'b0}}, rw_reg});
                    j_next       = j_reg + 1'b1;
                    if (j_reg == nt_walk_reg) begin
                        tab_vld_next = '0;
                        total_next   = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            tab_vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            tab_vld_reg <= tab_vld_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        rd_vld_reg  <= tab_vld_reg[raddr];
        j_reg       <= j_next;
        nt_walk_reg <= nt_walk_next;
        at_risk_reg <= at_risk_next;
        rw_reg      <= rw_next;
        surv_reg    <= surv_next;
        if (out_load) begin
            m_bin_index_reg  <= j_reg;
            m_survival_reg   <= surv_reg;
            m_curve_last_reg <= (j_reg == nt_walk_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_bin_index  = m_bin_index_reg;
    assign m_survival   = m_survival_reg;
    assign m_curve_last = m_curve_last_reg;

endmodule

// File: rtl/weighted_kaplan_meier.sv
// ----------------------------------------------------------------------------
// weighted_kaplan_meier: weighted Kaplan-Meier survival curve generator
// Accumulates weighted subjects per time bin and, on the last subject of a
// batch, issues one Q1.16 survival value per bin from 0 to num_times.
// ----------------------------------------------------------------------------
// A batch is a run of subject items ending in one with s_batch_last set. Each
// subject adds its Q8.16 weight to the removal table at its bin, to the event
// table if it is an event, and to the total; all accumulators saturate at
// 40 bits. Subjects whose bin lies above num_times (clamped to TIME_BINS-1)
// are dropped. After the last subject the block issues items for bins 0 up
// to num_times, with m_curve_last on the final one, and clears its tables.
// Timing: the front end takes an item in any cycle its four-entry queue has
// room. The back end reads the table and then does a saturating write-back
// for each kept subject, and only pops a dropped one. The curve starts with
// a setup read and calculation and the output for bin 0; each later bin
// takes a table read, a decision step, a survival update in the bit-serial
// unit (17 steps) when the at-risk weight is positive and above the event
// weight, and an output step. There is no clearing pass: each table entry
// carries a valid bit that reset and the end of a curve clear.
// num_times may be written only while the block is idle.
// ----------------------------------------------------------------------------
module weighted_kaplan_meier
    import kmw_pkg::*;
#(
    parameter int TIME_BINS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_wr_en,
    input  logic [BIN_W-1:0]  cfg_wr_data,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BIN_W-1:0]  s_time_bin,
    input  logic              s_is_event,
    input  logic [W_W-1:0]    s_weight,
    input  logic              s_batch_last,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [BIN_W-1:0]  m_bin_index,
    output logic [SURV_W-1:0] m_survival,
    output logic              m_curve_last
);

    localparam logic [BIN_W-1:0] NT_MAX = BIN_W'(TIME_BINS - 1);

    logic [BIN_W-1:0] num_times_reg;
    logic [BIN_W-1:0] nt_eff;
    logic             q_valid;
    logic             q_pop;
    kmw_item_t        q_item;

    // The single configuration register; it resets to the widest range.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_times_reg <= BIN_W'(63);
        end else if (cfg_wr_en) begin
            num_times_reg <= cfg_wr_data;
        end
    end

    // Values beyond the table depth behave as the last bin.
    assign nt_eff = (num_times_reg > NT_MAX) ? NT_MAX : num_times_reg;

    kmw_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_time_bin   (s_time_bin),
        .s_is_event   (s_is_event),
        .s_weight     (s_weight),
        .s_batch_last (s_batch_last),
        .nt_eff       (nt_eff),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    kmw_back #(.TIME_BINS(TIME_BINS)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .nt_eff       (nt_eff),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bin_index  (m_bin_index),
        .m_survival   (m_survival),
        .m_curve_last (m_curve_last)
    );

`ifndef SYNTHESIS
    // The first value of every curve is exactly one.
    a_bin0_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_bin_index == '0) |-> m_survival == ONE_Q16)
        else $error("bin 0 survival is not one");

    // The survival update never produces more than one.
    a_surv_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_survival <= ONE_Q16)
        else $error("survival above one");

    // Within a curve the survival never rises from one item to the next.
    a_surv_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_curve_last |=>
            !m_valid || (m_survival <= $past(m_survival)))
        else $error("survival increased within a curve");
`endif

endmodule
